[design/kvi_pkg.sv]
`timescale 1ns / 1ps
// Shared types, sizes and codes for the keyframe vector interpolator.
// No dependencies; every design file but kvi_ram imports this package.
package kvi_pkg;

  localparam int MAX_KEYS       = 64;
  localparam int COMPONENT_BITS = 32;

  localparam int KEY_AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W   = $clog2(MAX_KEYS + 1);
  localparam int FRAME_W = 16;
  localparam int TIME_W  = 24;
  localparam int FIELD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int KEY_W   = FRAME_W + 3 * COMPONENT_BITS;
  localparam int PROD_W  = COMPONENT_BITS + 1 + FRAC_W + 1;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 96;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Input kind codes.
  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef logic [COMPONENT_BITS-1:0] comp_t;

  typedef struct packed {
    comp_t [2:0]        vec;
    logic [FRAME_W-1:0] frame;
  } key_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              ram_we;
    logic [KEY_AW-1:0] ram_addr;
    logic              load_t;
    logic              res_ld_status;
    logic [1:0]        res_status;
    logic              res_zero;
    logic              res_cur;
    logic              shift_prev;
    logic              div_init;
    logic              div_step;
    logic              mul;
    logic              add;
    logic [1:0]        comp;
    logic              out_load;
  } kvi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic eq;
    logic gt;
  } kvi_stat_t;

  // Takes a 32-bit input field into component width, sign taken from the top component bit.
  function automatic comp_t field_to_comp(input logic [FIELD_W-1:0] f);
    logic [63:0] w;
    w = {32'b0, f};
    return w[COMPONENT_BITS-1:0];
  endfunction

  // Sign-extends or truncates a component to the 32-bit output field.
  function automatic logic [FIELD_W-1:0] comp_to_field(input comp_t v);
    logic signed [63:0] w;
    w = 64'(signed'(v));
    return w[FIELD_W-1:0];
  endfunction

endpackage

[design/kvi_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module kvi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/kvi_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: key count, scan index, divide and mix sequencing.
// Depends on kvi_pkg.
module kvi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  kvi_pkg::kvi_stat_t stat,
  output kvi_pkg::kvi_cmd_t  cmd
);
  import kvi_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [KEY_AW-1:0] idx, idx_next;
  logic [3:0]        step, step_next;
  logic [1:0]        comp, comp_next;
  logic              out_free;
  logic              last_key;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign last_key = (CNT_W'(idx) + CNT_W'(1)) == count;

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    step_next  = step;
    comp_next  = comp;
    cmd        = '0;
    cmd.comp   = comp;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == MODE_APPEND) begin
            cmd.res_ld_status = 1'b1;
            cmd.res_zero      = 1'b1;
            state_next        = S_FIN;
            if (count == CNT_W'(MAX_KEYS)) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.res_status = ST_OK;
              cmd.ram_we     = 1'b1;
              cmd.ram_addr   = count[KEY_AW-1:0];
              count_next     = count + CNT_W'(1);
            end
          end else if (count == '0) begin
            cmd.res_ld_status = 1'b1;
            cmd.res_status    = ST_EMPTY;
            cmd.res_zero      = 1'b1;
            state_next        = S_FIN;
          end else begin
            cmd.load_t   = 1'b1;
            cmd.ram_addr = '0;
            idx_next     = '0;
            state_next   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Read data for key idx is present; the next key is already being fetched.
        cmd.ram_addr      = idx + KEY_AW'(1);
        cmd.res_ld_status = 1'b1;
        cmd.res_status    = ST_OK;
        if (stat.eq) begin
          cmd.res_cur = 1'b1;
          state_next  = S_FIN;
        end else if (stat.gt) begin
          if (idx == '0) begin
            cmd.res_cur = 1'b1;
            state_next  = S_FIN;
          end else begin
            cmd.div_init = 1'b1;
            step_next    = '0;
            state_next   = S_DIV;
          end
        end else begin
          cmd.shift_prev = 1'b1;
          if (last_key) begin
            cmd.res_cur = 1'b1;
            state_next  = S_FIN;
          end else begin
            idx_next = idx + KEY_AW'(1);
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 4'd1;
        if (step == 4'(FRAC_W - 1)) begin
          comp_next  = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (comp == 2'd2) begin
          state_next = S_FIN;
        end else begin
          comp_next  = comp + 2'd1;
          state_next = S_MUL;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      idx      <= '0;
      step     <= '0;
      comp     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      step  <= step_next;
      comp  <= comp_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[design/kvi_dp.sv]
`timescale 1ns / 1ps
// Datapath: key RAM, scan compare, bit-serial fraction divider, shared mix multiplier
// and the output register. Depends on kvi_pkg and kvi_ram.
module kvi_dp (
  input  logic                               clk,
  input  logic [kvi_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic [kvi_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic [1:0]                         m_tuser,
  input  kvi_pkg::kvi_cmd_t                  cmd,
  output kvi_pkg::kvi_stat_t                 stat
);
  import kvi_pkg::*;

  key_entry_t           wentry;
  key_entry_t           cur;
  logic [TIME_W-1:0]    t_reg;
  key_entry_t           prev;
  comp_t [2:0]          b_vec;
  logic [TIME_W-1:0]    rem;
  logic [TIME_W-1:0]    den;
  logic [FRAC_W-1:0]    quo;
  logic [TIME_W:0]      rem2;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] mix_sum;
  logic signed [COMPONENT_BITS:0] diff;
  logic [TIME_W-1:0]    cur_t;
  logic [TIME_W-1:0]    prev_t;
  comp_t [2:0]          res_vec;
  logic [1:0]           res_status;

  assign wentry.frame  = s_tdata[TIME_W-1:8];
  assign wentry.vec[0] = field_to_comp(s_tdata[55:24]);
  assign wentry.vec[1] = field_to_comp(s_tdata[87:56]);
  assign wentry.vec[2] = field_to_comp(s_tdata[119:88]);

  kvi_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_KEYS)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (cmd.ram_addr),
    .wdata (wentry),
    .raddr (cmd.ram_addr),
    .rdata (cur)
  );

  assign cur_t   = {cur.frame, 8'b0};
  assign prev_t  = {prev.frame, 8'b0};
  assign stat.eq = (cur_t == t_reg);
  assign stat.gt = (cur_t > t_reg);

  assign rem2 = {rem, 1'b0};
  assign diff = $signed({b_vec[cmd.comp][COMPONENT_BITS-1], b_vec[cmd.comp]})
              - $signed({prev.vec[cmd.comp][COMPONENT_BITS-1], prev.vec[cmd.comp]});
  // Rounds towards minus infinity, which keeps the result between the two keys.
  assign mix_sum = PROD_W'(signed'(prev.vec[cmd.comp])) + (prod >>> FRAC_W);

  always_ff @(posedge clk) begin
    if (cmd.load_t) begin
      t_reg <= s_tdata[TIME_W-1:0];
    end
    if (cmd.shift_prev) begin
      prev <= cur;
    end
    if (cmd.div_init) begin
      b_vec <= cur.vec;
      rem   <= t_reg - prev_t;
      den   <= cur_t - prev_t;
      quo   <= '0;
    end else if (cmd.div_step) begin
      if (rem2 >= {1'b0, den}) begin
        rem <= TIME_W'(rem2 - {1'b0, den});
        quo <= {quo[FRAC_W-2:0], 1'b1};
      end else begin
        rem <= rem2[TIME_W-1:0];
        quo <= {quo[FRAC_W-2:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      prod <= diff * $signed({1'b0, quo});
    end
    if (cmd.res_ld_status) begin
      res_status <= cmd.res_status;
    end
    if (cmd.res_zero) begin
      res_vec <= '0;
    end else if (cmd.res_cur) begin
      res_vec <= cur.vec;
    end else if (cmd.add) begin
      res_vec[cmd.comp] <= mix_sum[COMPONENT_BITS-1:0];
    end
    if (cmd.out_load) begin
      m_tuser <= res_status;
      m_tdata <= {comp_to_field(res_vec[2]), comp_to_field(res_vec[1]),
                  comp_to_field(res_vec[0])};
    end
  end

endmodule

[design/keyframe_vec3_interpolator_core.sv]
`timescale 1ns / 1ps
// Keyframe track interpolator: one result word for every input word, append or sample.
// An append goes from the idle state to the finish state, which loads the result once the
// output is free. A sample scans the keys in order (the key RAM delivers one key a cycle, up
// to MAX_KEYS keys) and, when it lands between two keys, runs the bit-serial fraction divider
// and then the mix, which shares one multiplier across the three components. The input
// reopens once the result is loaded into the output register. One word is in flight at a
// time; a finished result may wait in the output register while the next word is taken.
// Keys are not cleared by reset, only the count, so the block is ready straight after reset.
// Depends on kvi_pkg, kvi_ctrl and kvi_dp.
module keyframe_vec3_interpolator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // frame_time [23:0], value_x [55:24], value_y [87:56], value_z [119:88]
  input  logic [kvi_pkg::IN_DATA_W-1:0]  s_tdata,
  // mode [0]
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_x [31:0], out_y [63:32], out_z [95:64]
  output logic [kvi_pkg::OUT_DATA_W-1:0] m_tdata,
  // status [1:0]
  output logic [1:0]                    m_tuser
);
  import kvi_pkg::*;

  kvi_cmd_t  cmd;
  kvi_stat_t stat;

  kvi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kvi_dp u_dp (
    .clk     (clk),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

[design/kvi_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the keyframe interpolator, bound to the top level.
// Depends on kvi_pkg and keyframe_vec3_interpolator_core.
module kvi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [kvi_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]                    m_tuser
);
  import kvi_pkg::*;

  // A result held back by the sink keeps its word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // Only one word is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a word is in progress");

  // Dropped appends and empty samples carry a zero vector.
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_EMPTY) |-> m_tdata == '0)
    else $error("flagged result with non-zero vector");

  // Status never takes the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_FULL || m_tuser == ST_EMPTY))
    else $error("bad status code");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind keyframe_vec3_interpolator_core kvi_checker u_kvi_checker (.*);
